### rtl/core/a2r_pkg.sv
// Shared types, constants and helpers for the axis-angle to rotation matrix block.
package a2r_pkg;

  localparam int CordicSteps = 16;
  localparam int AngW        = 17;
  localparam int AxW         = 16;
  localparam int OutW        = 18;
  localparam int VecW        = 32;
  localparam int ZW          = 32;
  localparam logic [VecW-1:0] CordicGain = 32'sd163008218;
  localparam logic signed [17:0] TurnUnits    = 18'sd46080;
  localparam logic signed [17:0] QuarterUnits = 18'sd11520;

  // Payload carried along the cordic chain.
  typedef struct packed {
    logic                   vld;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    logic [1:0]             quad;
    logic signed [AxW-1:0]  ax;
    logic signed [AxW-1:0]  ay;
    logic signed [AxW-1:0]  az;
  } cord_t;

  // Arctangent of 2^-i in units of 1/8388608 degree.
  function automatic logic signed [ZW-1:0] atan_f(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        4'd0:  r = 32'sd377487360;
        4'd1:  r = 32'sd222843801;
        4'd2:  r = 32'sd117744544;
        4'd3:  r = 32'sd59768969;
        4'd4:  r = 32'sd30000467;
        4'd5:  r = 32'sd15014858;
        4'd6:  r = 32'sd7509261;
        4'd7:  r = 32'sd3754860;
        4'd8:  r = 32'sd1877459;
        4'd9:  r = 32'sd938733;
        4'd10: r = 32'sd469367;
        4'd11: r = 32'sd234684;
        4'd12: r = 32'sd117342;
        4'd13: r = 32'sd58671;
        4'd14: r = 32'sd29335;
        default: r = 32'sd14668;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/core/a2r_cell.sv
// One CORDIC rotation cell with a fixed shift, registered output.
module a2r_cell import a2r_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [3:0] step_i,
  input  cord_t      in_i,
  output cord_t      out_o
);
  cord_t d, q;
  logic signed [VecW-1:0] xs, ys;
  logic signed [ZW-1:0]   at;

  // Rotate towards zero residual angle.
  always_comb begin
    xs = in_i.x >>> step_i;
    ys = in_i.y >>> step_i;
    at = atan_f(step_i);
    d  = in_i;
    if (!in_i.z[ZW-1]) begin
      d.x = in_i.x - ys;
      d.y = in_i.y + xs;
      d.z = in_i.z - at;
    end else begin
      d.x = in_i.x + ys;
      d.y = in_i.y - xs;
      d.z = in_i.z + at;
    end
  end

  // Only the valid flag is cleared by reset; the payload simply follows it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q.vld <= 1'b0;
    end else if (en_i) begin
      q <= d;
    end
  end

  assign out_o = q;
endmodule

### rtl/core/axis_angle_to_rotation_matrix.sv
// Top level: angle reduction, CORDIC cell chain and Rodrigues matrix pipeline.
//
// Input words on s_axis carry angle (1/128 degree) and a Q2.14 axis; output
// words on m_axis carry the nine Q4.14 entries and a saturation flag.
// The angle is wrapped to one turn and split into quadrant and residual
// (two stages), passed through a chain of 16 CORDIC cells, rounded and
// mapped to the quadrant, then multiplied out over three stages and
// rounded, clamped and registered.
// One word is accepted every cycle while s_axis_tready is high; the whole
// pipeline advances together at one word per cycle whenever it is not frozen.
// When m_axis_tready is low with a word waiting in the output register,
// the pipeline freezes and s_axis_tready falls; an empty output register
// lets the pipeline advance regardless of the receiver.
// Reset clears all valid flags; no word is in flight after reset.
module axis_angle_to_rotation_matrix import a2r_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // angle_deg[16:0], axis_x[32:17], axis_y[48:33], axis_z[64:49]
  input  logic [71:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // m00..m22 at 18 bits each from bit 0, saturated at bit 162
  output logic [167:0]  m_axis_tdata
);
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: modulo one turn.
  logic signed [AngW-1:0] ang;
  logic signed [17:0] m_d;
  logic a_vld_q;
  logic signed [17:0] a_m_q;
  logic signed [AxW-1:0] a_ax_q, a_ay_q, a_az_q;
  assign ang = s_axis_tdata[16:0];
  always_comb begin
    m_d = 18'(ang);
    if (m_d < 0) m_d = m_d + TurnUnits;
    if (m_d < 0) m_d = m_d + TurnUnits;
    if (m_d >= TurnUnits) m_d = m_d - TurnUnits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_m_q <= m_d;
      a_ax_q <= s_axis_tdata[32:17];
      a_ay_q <= s_axis_tdata[48:33];
      a_az_q <= s_axis_tdata[64:49];
    end
  end

  // Stage B: quadrant split, CORDIC seed.
  cord_t seed, seed_q;
  cord_t chain [CordicSteps+1];
  logic signed [17:0] r;
  logic [1:0] qd;
  always_comb begin
    qd = 2'd0;
    r  = a_m_q;
    if (a_m_q >= 3*QuarterUnits) begin qd = 2'd3; r = 18'(a_m_q - 3*QuarterUnits); end
    else if (a_m_q >= 2*QuarterUnits) begin qd = 2'd2; r = 18'(a_m_q - 2*QuarterUnits); end
    else if (a_m_q >= QuarterUnits) begin qd = 2'd1; r = 18'(a_m_q - QuarterUnits); end
    seed.vld  = a_vld_q;
    seed.x    = CordicGain;
    seed.y    = '0;
    seed.z    = {r[15:0], 16'd0};
    seed.quad = qd;
    seed.ax   = a_ax_q;
    seed.ay   = a_ay_q;
    seed.az   = a_az_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q.vld <= 1'b0;
    else if (en) seed_q <= seed;
  end
  assign chain[0] = seed_q;

  // Row of CORDIC cells.
  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    a2r_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .step_i (4'(g)), .in_i (chain[g]), .out_o (chain[g+1])
    );
  end

  // Stage C: round to Q14, clamp, quadrant map.
  cord_t ce;
  logic signed [VecW-1:0] xr, yr;
  logic signed [17:0] c0, s0, c_d, s_d;
  logic c_vld_q;
  logic signed [17:0] c_q, s_q, u_q;
  logic signed [AxW-1:0] c_ax_q, c_ay_q, c_az_q;
  assign ce = chain[CordicSteps];
  always_comb begin
    xr = (ce.x + 32'sd8192) >>> 14;
    yr = (ce.y + 32'sd8192) >>> 14;
    c0 = (xr > 16384) ? 18'sd16384 : (xr < -16384) ? -18'sd16384 : 18'(xr);
    s0 = (yr > 16384) ? 18'sd16384 : (yr < -16384) ? -18'sd16384 : 18'(yr);
    unique case (ce.quad)
      2'd0: begin c_d = c0;  s_d = s0;  end
      2'd1: begin c_d = -s0; s_d = c0;  end
      2'd2: begin c_d = -c0; s_d = -s0; end
      default: begin c_d = s0; s_d = -c0; end
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= ce.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d; s_q <= s_d; u_q <= 18'sd16384 - c_d;
      c_ax_q <= ce.ax; c_ay_q <= ce.ay; c_az_q <= ce.az;
    end
  end

  // Stage D: axis products and sine terms.
  logic d_vld_q;
  logic signed [31:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [33:0] sx_q, sy_q, sz_q;
  logic signed [17:0] d_c_q, d_u_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= 32'(c_ax_q) * 32'(c_ax_q); pyy_q <= 32'(c_ay_q) * 32'(c_ay_q);
      pzz_q <= 32'(c_az_q) * 32'(c_az_q);
      pxy_q <= 32'(c_ax_q) * 32'(c_ay_q); pxz_q <= 32'(c_ax_q) * 32'(c_az_q);
      pyz_q <= 32'(c_ay_q) * 32'(c_az_q);
      sx_q <= 34'(c_ax_q) * 34'(s_q); sy_q <= 34'(c_ay_q) * 34'(s_q);
      sz_q <= 34'(c_az_q) * 34'(s_q);
      d_c_q <= c_q; d_u_q <= u_q;
    end
  end

  // Stage E: scale by u and form the nine Q42 sums.
  logic e_vld_q;
  logic signed [51:0] pu [6];
  logic signed [51:0] e_q [9];
  logic signed [51:0] cq, xs, ys, zs;
  always_comb begin
    pu[0] = 52'(pxx_q) * 52'(d_u_q); pu[1] = 52'(pyy_q) * 52'(d_u_q);
    pu[2] = 52'(pzz_q) * 52'(d_u_q); pu[3] = 52'(pxy_q) * 52'(d_u_q);
    pu[4] = 52'(pxz_q) * 52'(d_u_q); pu[5] = 52'(pyz_q) * 52'(d_u_q);
    cq = 52'(d_c_q) <<< 28;
    xs = 52'(sx_q) <<< 14;
    ys = 52'(sy_q) <<< 14;
    zs = 52'(sz_q) <<< 14;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= d_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= pu[0] + cq; e_q[1] <= pu[3] - zs; e_q[2] <= pu[4] + ys;
      e_q[3] <= pu[3] + zs; e_q[4] <= pu[1] + cq; e_q[5] <= pu[5] - xs;
      e_q[6] <= pu[4] - ys; e_q[7] <= pu[5] + xs; e_q[8] <= pu[2] + cq;
    end
  end

  // Stage F: round, clamp and hold the output word.
  logic signed [51:0] rnd [9];
  logic [OutW-1:0] ent [9];
  logic [8:0] clip;
  logic out_vld_q;
  logic [167:0] out_q, out_d;
  always_comb begin
    out_d = '0;
    for (int k = 0; k < 9; k++) begin
      rnd[k] = (e_q[k] + (52'sd1 <<< 27)) >>> 28;
      clip[k] = 1'b0;
      ent[k] = rnd[k][OutW-1:0];
      if (rnd[k] > 52'sd131071) begin ent[k] = 18'h1FFFF; clip[k] = 1'b1; end
      else if (rnd[k] < -52'sd131072) begin ent[k] = 18'h20000; clip[k] = 1'b1; end
      out_d[k*OutW +: OutW] = ent[k];
    end
    out_d[162] = |clip;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= e_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule

### tb/axis_angle_to_rotation_matrix_tb.sv
// Testbench for the axis-angle to rotation matrix block, with a matrix predictor and scoreboard.
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix_tb import a2r_pkg::*; ();

  typedef struct packed {
    logic signed [16:0] ang;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } rot_in_t;

  typedef struct {
    logic signed [17:0] m [9];
    logic               sat;
  } rot_mat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // angle_deg, axis_x, axis_y, axis_z from the lowest bit up
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // m00..m22 at 18 bits each, then saturated
  logic [167:0] m_axis_tdata;

  rot_mat_t matrices_due [$];
  int       n_errors = 0;
  int       n_words = 0;
  int       n_matrices = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  axis_angle_to_rotation_matrix DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #2 clk_i = ~clk_i;

  // Floor shift for signed 64-bit values.
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, ref logic sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Cosine and sine in Q14 by a 16-step CORDIC on the residual of the quadrant.
  function automatic void predict_sincos(input longint ang, output longint co,
                                         output longint si);
    longint md, q, r, x, y, z, xs, ys, c, s;
    logic   unused;
    unused = 1'b0;
    md = ang % 46080;
    if (md < 0) md += 46080;
    q = md / 11520;
    r = md - q * 11520;
    x = 163008218;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_f(i[3:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_f(i[3:0]));
      end
    end
    c = clip(floor_shr(x + 8192, 14), -16384, 16384, unused);
    s = clip(floor_shr(y + 8192, 14), -16384, 16384, unused);
    case (q)
      0: begin co = c;  si = s;  end
      1: begin co = -s; si = c;  end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic rot_mat_t predict_matrix(rot_in_t w);
    rot_mat_t res;
    longint   c, s, u, cq, dx, dy, dz, xs, ys, zs;
    longint   q42 [9];
    predict_sincos(longint'(w.ang), c, s);
    dx = w.ax; dy = w.ay; dz = w.az;
    u = 16384 - c;
    cq = c <<< 28;
    xs = dx * s * 16384;
    ys = dy * s * 16384;
    zs = dz * s * 16384;
    q42[0] = dx * dx * u + cq;
    q42[1] = dx * dy * u - zs;
    q42[2] = dz * dx * u + ys;
    q42[3] = dx * dy * u + zs;
    q42[4] = dy * dy * u + cq;
    q42[5] = dz * dy * u - xs;
    q42[6] = dx * dz * u - ys;
    q42[7] = dy * dz * u + xs;
    q42[8] = dz * dz * u + cq;
    res.sat = 1'b0;
    for (int k = 0; k < 9; k++)
      res.m[k] = 18'(clip(floor_shr(q42[k] + (64'sd1 <<< 27), 28), -131072, 131071, res.sat));
    return res;
  endfunction

  // Send one word, predicting its matrix at the moment it is accepted.
  // The valid line stays high between back-to-back words and drops only while idling.
  task automatic send_word(rot_in_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, w.az, w.ay, w.ax, w.ang};
    do @(posedge clk_i); while (!s_axis_tready);
    matrices_due.push_back(predict_matrix(w));
    n_words++;
  endtask

  // Drop the valid line and wait until every expected matrix has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (matrices_due.size() != 0);
  endtask

  // Receiver stalls.
  always @(posedge clk_i) begin
    m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted matrix against the oldest prediction.
  always @(posedge clk_i) begin
    rot_mat_t exp_m;
    logic signed [17:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_matrices++;
      if (matrices_due.size() == 0) begin
        $error("matrix arrived with none expected");
        n_errors++;
      end else begin
        exp_m = matrices_due.pop_front();
        for (int k = 0; k < 9; k++) begin
          got = m_axis_tdata[k*18 +: 18];
          if (got !== exp_m.m[k]) begin
            $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3, exp_m.m[k], got);
            n_errors++;
          end
        end
        if (m_axis_tdata[162] !== exp_m.sat) begin
          $error("saturated expected %0d actual %0d", exp_m.sat, m_axis_tdata[162]);
          n_errors++;
        end
      end
    end
  end

  function automatic rot_in_t rand_word();
    rot_in_t w;
    int      sel;
    sel = $urandom_range(9);
    w.ang = 17'($signed($urandom_range(92160)) - 46080);
    if (sel == 0) w.ang = 17'($urandom());
    w.ax = 16'($urandom()); w.ay = 16'($urandom()); w.az = 16'($urandom());
    // Mostly axis components within +-1.0 (Q2.14); the rest take any 16-bit value.
    if (sel > 3) begin
      w.ax = 16'($signed($urandom_range(32768)) - 16384);
      w.ay = 16'($signed($urandom_range(32768)) - 16384);
      w.az = 16'($signed($urandom_range(32768)) - 16384);
    end
    return w;
  endfunction

  task automatic test_directed();
    int angs [12] = '{0, 11520, 23040, 34560, 46080, -46080, -11520, 1, -1, 65535, -65536,
                      5760};
    foreach (angs[i]) send_word('{17'(angs[i]), 16'sd16384, 16'sd0, 16'sd0});
    send_word('{17'sd5760, 16'sd0, 16'sd16384, 16'sd0});
    send_word('{17'sd5760, 16'sd0, 16'sd0, 16'sd16384});
    send_word('{17'sd23040, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_word('{17'sd23040, 16'sh8000, 16'sh8000, 16'sh8000});
    send_word('{17'sd11520, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_word('{17'sd34560, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_word('{17'sd8000, 16'sd9459, 16'sd9459, 16'sd9459});
    send_word('{17'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_word('{-17'sd30000, 16'shffff, 16'sh5555, 16'shaaaa});
  endtask

  task automatic test_random(int n, int sp, int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int i = 0; i < n; i++) send_word(rand_word());
  endtask

  // Hold the sender until the pipeline has drained, then send three random words.
  task automatic test_drain_pause();
    wait_drained();
    repeat (3) send_word(rand_word());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 14;
    recv_idle_pct = 59;
    test_directed();
    test_random(650, 14, 59);
    test_drain_pause();
    test_random(650, 59, 14);
    test_random(650, 0, 0);
    wait_drained();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d words and checked %0d matrices over varied angles, axes and stalls.",
             n_words, n_matrices);
    if (n_errors == 0 && matrices_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
